FILE: hdl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition that must never be seen on a clock edge
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`endif

FILE: hdl/sha_pkg.sv
package sha_pkg;
	localparam int FIFO_DEPTH = 4;

	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} blk_word_t;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [31:0] PAD_WORD = 32'h80000000;
endpackage

FILE: hdl/sha_front.sv
// Pads the message: turns input beats into a stream of block words.
module sha_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [31:0]            in_word,
	input  logic [2:0]             in_count,
	input  logic                   in_last,
	output logic                   w_valid,
	input  logic                   w_ready,
	output sha_pkg::blk_word_t     w_data
);
	typedef enum logic [3:0] {
		ST_TAKE = 4'b0001,
		ST_PAD  = 4'b0010,
		ST_ZERO = 4'b0100,
		ST_LEN  = 4'b1000
	} fstate_t;

	fstate_t     state_q;
	logic [63:0] len_q;
	logic [3:0]  fill_q;
	logic        hi_q;
	logic [2:0]  cnt;
	logic [31:0] keep;
	logic [63:0] len_n;

	assign cnt = (in_count > 3'd4 || !in_last) ? 3'd4 : in_count;
	assign len_n = len_q + {58'd0, cnt, 3'd0};
	assign in_ready = (state_q == ST_TAKE) && w_ready;

	always_comb begin
		keep = (cnt == 3'd0) ? 32'd0 : ~(32'hffffffff >> {cnt, 3'd0});
		w_valid = 1'b1;
		w_data.last = 1'b0;
		unique case (state_q)
			ST_TAKE: begin
				w_valid = in_valid;
				if (!in_last || cnt == 3'd4) w_data.word = in_word;
				else w_data.word = (in_word & keep) | (sha_pkg::PAD_WORD >> {cnt, 3'd0});
			end
			ST_PAD:  w_data.word = sha_pkg::PAD_WORD;
			ST_ZERO: w_data.word = 32'd0;
			ST_LEN: begin
				w_data.word = hi_q ? len_q[63:32] : len_q[31:0];
				w_data.last = !hi_q;
			end
			default: w_data.word = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_TAKE;
			len_q <= '0;
			fill_q <= '0;
			hi_q <= 1'b1;
		end else if (w_valid && w_ready) begin
			fill_q <= fill_q + 4'd1;
			unique case (state_q)
				ST_TAKE: begin
					len_q <= len_n;
					if (in_last) begin
						if (cnt == 3'd4) state_q <= ST_PAD;
						else if (fill_q + 4'd1 == 4'd14) state_q <= ST_LEN;
						else state_q <= ST_ZERO;
					end
				end
				ST_PAD, ST_ZERO: begin
					state_q <= (fill_q + 4'd1 == 4'd14) ? ST_LEN : ST_ZERO;
				end
				ST_LEN: begin
					hi_q <= !hi_q;
					if (!hi_q) begin
						state_q <= ST_TAKE;
						len_q <= '0;
					end
				end
				default: state_q <= ST_TAKE;
			endcase
		end
	end
endmodule

FILE: hdl/sha_fifo.sv
// Short queue between padding and compression.
module sha_fifo #(
	parameter int DEPTH = sha_pkg::FIFO_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_valid,
	output logic               wr_ready,
	input  sha_pkg::blk_word_t wr_data,
	output logic               rd_valid,
	input  logic               rd_ready,
	output sha_pkg::blk_word_t rd_data
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	sha_pkg::blk_word_t mem_q [DEPTH];
	logic [AW:0] cnt_q;
	logic [AW-1:0] wp_q, rp_q;
	logic wr, rd;

	assign wr_ready = cnt_q != (AW+1)'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) if (wr) mem_q[wp_q] <= wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end
endmodule

FILE: hdl/sha_core.sv
`include "assert_macros.svh"
// Collects 16 words, runs 64 rounds one per cycle, emits digest at message end.
module sha_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               w_valid,
	output logic               w_ready,
	input  sha_pkg::blk_word_t w_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        out_word,
	output logic [2:0]         out_index,
	output logic               out_last
);
	typedef enum logic [3:0] {
		C_FILL = 4'b0001,
		C_RUN  = 4'b0010,
		C_ADD  = 4'b0100,
		C_OUT  = 4'b1000
	} cstate_t;

	cstate_t     state_q;
	logic [31:0] sched_q [16];
	logic [31:0] hash_q [8];
	logic [31:0] v_q [8];
	logic [3:0]  fill_q;
	logic [5:0]  rnd_q;
	logic [2:0]  idx_q;
	logic        fin_q;
	logic [31:0] wj, s0, s1, big0, big1, ch, maj, t1, t2, wnew;

	function automatic logic [31:0] ror(input logic [31:0] v, input int n);
		ror = (v >> n) | (v << (32 - n));
	endfunction

	assign w_ready = state_q == C_FILL;
	assign out_valid = state_q == C_OUT;
	assign out_word = hash_q[idx_q];
	assign out_index = idx_q;
	assign out_last = idx_q == 3'd7;

	always_comb begin
		wj = sched_q[0];
		s0 = ror(sched_q[1], 7) ^ ror(sched_q[1], 18) ^ (sched_q[1] >> 3);
		s1 = ror(sched_q[14], 17) ^ ror(sched_q[14], 19) ^ (sched_q[14] >> 10);
		wnew = sched_q[0] + s0 + sched_q[9] + s1;
		big1 = ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25);
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + big1 + ch + sha_pkg::ROUND_K[rnd_q] + wj;
		big0 = ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2 = big0 + maj;
	end

	// schedule window is a shift line: word j sits at tap 0
	always_ff @(posedge clk) begin
		if (state_q == C_FILL && w_valid) begin
			for (int i = 0; i < 15; i++) sched_q[i] <= sched_q[i+1];
			sched_q[15] <= w_data.word;
			if (fill_q == 4'd15) for (int i = 0; i < 8; i++) v_q[i] <= hash_q[i];
		end else if (state_q == C_RUN) begin
			for (int i = 0; i < 15; i++) sched_q[i] <= sched_q[i+1];
			sched_q[15] <= wnew;
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_FILL;
			fill_q <= '0;
			rnd_q <= '0;
			idx_q <= '0;
			fin_q <= 1'b0;
			for (int i = 0; i < 8; i++) hash_q[i] <= sha_pkg::INIT_HASH[i];
		end else begin
			unique case (state_q)
				C_FILL: if (w_valid) begin
					fill_q <= fill_q + 4'd1;
					if (fill_q == 4'd15) begin
						state_q <= C_RUN;
						rnd_q <= '0;
						fin_q <= w_data.last;
					end
				end
				C_RUN: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= C_ADD;
				end
				C_ADD: begin
					for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + v_q[i];
					state_q <= fin_q ? C_OUT : C_FILL;
					idx_q <= '0;
				end
				C_OUT: if (out_ready) begin
					idx_q <= idx_q + 3'd1;
					if (idx_q == 3'd7) begin
						state_q <= C_FILL;
						for (int i = 0; i < 8; i++) hash_q[i] <= sha_pkg::INIT_HASH[i];
					end
				end
				default: state_q <= C_FILL;
			endcase
		end
	end

	`ASSERT_CLK(a_fill_idle, (state_q != C_FILL) |-> (fill_q == 4'd0), "fill count off")
	`ASSERT_CLK(a_run_end, (state_q == C_ADD) |-> $past(rnd_q) == 6'd63, "round count off")
	`ASSERT_CLK(a_out_idx, (state_q == C_OUT && $past(state_q) == C_ADD) |-> idx_q == 3'd0,
		"digest index off")
	`ASSERT_NEVER(a_fill_during_out, w_ready && out_valid, "fill while digest pending")
endmodule

FILE: hdl/sha256_message_hasher.sv
// SHA-256 message hasher.
// Slave channel s_axis_*: one beat per message word, big-endian, first byte in
// bits 31..24; tuser gives the valid byte count, tlast marks the final word.
// Master channel m_axis_*: eight beats per message, digest words h0..h7,
// tuser holds the word index, tlast is set on h7.
// A padding front turns beats into block words and feeds a four-entry queue;
// the compression back end collects 16 words, then runs 64 rounds at one
// round per cycle and folds the result into the chaining hash; it takes no
// words of the next block until that fold is done.
// The last word adds 2 to 18 padding words (one extra block if needed).
// The digest appears after the final block's rounds and stays while
// m_axis_tready is low; input then backs up through the queue.
// After h7 is taken the hash returns to the initial values.
// Reset (arst_n low) clears the queue and length counter and loads the initial hash values.
module sha256_message_hasher #(
	parameter int FIFO_DEPTH = sha_pkg::FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // message_word
	input  logic [2:0]  s_axis_tuser,  // byte_count
	input  logic        s_axis_tlast,  // last_word
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // digest_word
	output logic [2:0]  m_axis_tuser,  // word_index
	output logic        m_axis_tlast   // last_digest
);
	logic f_valid, f_ready, q_valid, q_ready;
	sha_pkg::blk_word_t f_data, q_data;

	sha_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_word(s_axis_tdata), .in_count(s_axis_tuser), .in_last(s_axis_tlast),
		.w_valid(f_valid), .w_ready(f_ready), .w_data(f_data));

	sha_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data));

	sha_core u_core (
		.clk(clk), .arst_n(arst_n),
		.w_valid(q_valid), .w_ready(q_ready), .w_data(q_data),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_word(m_axis_tdata), .out_index(m_axis_tuser), .out_last(m_axis_tlast));
endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  count;
		logic        last;
	} msg_beat_t;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_beat_t;

	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;  // message_word
	logic [2:0]  s_axis_tuser = '0;  // byte_count
	logic        s_axis_tlast = 1'b0; // last_word
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;  // digest_word
	logic [2:0]  m_axis_tuser;  // word_index
	logic        m_axis_tlast;  // last_digest

	sha256_message_hasher u_dut (.*);

	always #6 clk = ~clk;

	msg_beat_t    pending_beats[$];
	digest_beat_t expected_digest[$];
	int           error_count = 0;
	int           idle_cycles = 0;
	int           send_gap = 0;
	int           recv_gap = 0;
	bit           hold_send = 1'b0;

	// hasher state of the predictor
	logic [31:0] hash_h[8];
	logic [31:0] blk_w[16];
	logic [63:0] msg_bits;
	int          blk_fill;

	function automatic logic [31:0] rotr(logic [31:0] v, int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	task automatic hash_restart();
		for (int i = 0; i < 8; i++) hash_h[i] = sha_pkg::INIT_HASH[i];
		msg_bits = '0;
		blk_fill = 0;
	endtask

	task automatic compress();
		logic [31:0] w[64];
		logic [31:0] v[8];
		logic [31:0] t1, t2, e, a;
		for (int j = 0; j < 16; j++) w[j] = blk_w[j];
		for (int j = 16; j < 64; j++)
			w[j] = w[j-16] + w[j-7]
				+ (rotr(w[j-15], 7) ^ rotr(w[j-15], 18) ^ (w[j-15] >> 3))
				+ (rotr(w[j-2], 17) ^ rotr(w[j-2], 19) ^ (w[j-2] >> 10));
		for (int j = 0; j < 8; j++) v[j] = hash_h[j];
		for (int j = 0; j < 64; j++) begin
			e = v[4];
			a = v[0];
			t1 = v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
				+ ((e & v[5]) ^ (~e & v[6])) + sha_pkg::ROUND_K[j] + w[j];
			t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
				+ ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int j = 0; j < 8; j++) hash_h[j] += v[j];
	endtask

	task automatic load_word(logic [31:0] w);
		blk_w[blk_fill] = w;
		blk_fill = (blk_fill + 1) % 16;
		if (blk_fill == 0) compress();
	endtask

	task automatic queue_beat(msg_beat_t b);
		pending_beats.insert(pending_beats.size(), b);
	endtask

	task automatic hash_beat(msg_beat_t b);
		int n;
		logic [31:0] keep;
		n = (b.count > 4 || !b.last) ? 4 : b.count;
		if (!b.last) begin
			msg_bits += 32;
			load_word(b.word);
			return;
		end
		msg_bits += n * 8;
		if (n == 4) begin
			load_word(b.word);
			load_word(sha_pkg::PAD_WORD);
		end else begin
			keep = (n == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * n));
			load_word((b.word & keep) | (32'h80 << (24 - 8 * n)));
		end
		while (blk_fill != 14) load_word(32'h0);
		load_word(msg_bits[63:32]);
		load_word(msg_bits[31:0]);
		for (int k = 0; k < 8; k++)
			expected_digest.insert(expected_digest.size(), '{hash_h[k], 3'(k), k == 7});
		hash_restart();
	endtask

	function automatic int pick_gap();
		if ($urandom_range(0, 3) != 0) return 0;
		if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		error_count++;
	endtask

	task automatic add_msg(int words, int tail_count);
		for (int i = 0; i < words; i++)
			queue_beat('{$urandom(), 3'($urandom()), 1'b0});
		queue_beat('{$urandom(), 3'(tail_count), 1'b1});
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				hash_beat('{s_axis_tdata, s_axis_tuser, s_axis_tlast});
				send_gap <= pick_gap();
			end
			if ((!s_axis_tvalid || s_axis_tready) ) begin
				if (send_gap == 0 && pending_beats.size() != 0 && !hold_send
						&& !(s_axis_tvalid && s_axis_tready && send_gap != 0)) begin
					msg_beat_t b;
					b = pending_beats.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= b.word;
					s_axis_tuser  <= b.count;
					s_axis_tlast  <= b.last;
				end else begin
					s_axis_tvalid <= 1'b0;
					if (send_gap > 0 && !(s_axis_tvalid && s_axis_tready)) send_gap <= send_gap - 1;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_digest.size() == 0) begin
					report("unexpected beat", m_axis_tdata, 32'h0);
				end else begin
					digest_beat_t d;
					d = expected_digest.pop_front();
					if (m_axis_tdata !== d.word) report("digest_word", m_axis_tdata, d.word);
					if (m_axis_tuser !== d.index) report("word_index", m_axis_tuser, d.index);
					if (m_axis_tlast !== d.last) report("last_digest", m_axis_tlast, d.last);
				end
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_axis_tready <= 1'b0;
			end else if (m_axis_tready && $urandom_range(0, 5) == 0) begin
				recv_gap <= pick_gap();
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		int sent;
		hash_restart();
		// directed: empty message, every tail count, block-boundary lengths
		add_msg(0, 0);
		add_msg(0, 1);
		add_msg(0, 2);
		add_msg(0, 3);
		add_msg(0, 4);
		add_msg(0, 7);
		add_msg(13, 4);
		add_msg(14, 0);
		add_msg(14, 3);
		add_msg(15, 5);
		queue_beat('{32'hffffffff, 3'd1, 1'b0});
		queue_beat('{32'hffffffff, 3'd6, 1'b1});
		queue_beat('{32'h00000000, 3'd4, 1'b1});
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_beats.size() == 0);
		// hold the sender until every digest has drained
		hold_send = 1'b1;
		wait (expected_digest.size() == 0 && !s_axis_tvalid);
		hold_send = 1'b0;
		sent = 0;
		while (sent < 410) begin
			int n;
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 15);
			add_msg(n, $urandom_range(0, 7));
			sent += n + 1;
			wait (pending_beats.size() < 8);
		end
		wait (pending_beats.size() == 0 && !s_axis_tvalid);
		wait (expected_digest.size() == 0);
		repeat (200) @(posedge clk);
		if (error_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
